/* hdl/bfa_pkg.sv */
`default_nettype none

package bfa_pkg;

	// item field widths
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned FRAME_W  = 12;
	localparam int unsigned STATUS_W = 2;

	// configuration registers are 13 bits; effective frame counts never exceed 8191
	localparam int unsigned CNT_W     = 13;
	localparam int unsigned CFG_IDX_W = 1;

	// bitmap word geometry
	localparam int unsigned WORD_W = 32;
	localparam int unsigned BIT_W  = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 1'd1;

	localparam logic [CNT_W-1:0] FRAME_TOTAL_RST = 13'd4096;
	localparam logic [CNT_W-1:0] RESERVED_RST    = 13'd0;

	// commands
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd3;

	// which result the datapath captures
	typedef enum logic [2:0] {
		RES_FULL,
		RES_RANGE,
		RES_RESV,
		RES_LOOK,
		RES_ALLOC
	} res_sel_t;

	typedef struct packed {
		logic     clr_en;
		logic     ld_item;
		logic     rd_init;
		logic     rd_index;
		logic     scan_step;
		logic     wr_free;
		logic     wr_alloc;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic is_free;
		logic alloc_empty;
		logic idx_range;
		logic idx_resv;
		logic found;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* hdl/bfa_if.sv */
`default_nettype none

interface bfa_req_if;
	logic                      valid;
	logic                      ready;
	logic [bfa_pkg::CMD_W-1:0]   command;
	logic [bfa_pkg::FRAME_W-1:0] frame_index;

	modport source (output valid, output command, output frame_index, input ready);
	modport sink   (input valid, input command, input frame_index, output ready);
endinterface

interface bfa_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::FRAME_W-1:0]  result_frame;
	logic [bfa_pkg::STATUS_W-1:0] status;
	logic                         was_used;

	modport source (output valid, output result_frame, output status, output was_used,
		input ready);
	modport sink   (input valid, input result_frame, input status, input was_used,
		output ready);
endinterface

`default_nettype wire

/* hdl/bitmap_frame_allocator_core.sv */
`default_nettype none

// Channel | Dir | Payload                           | Handshake
// req     | in  | command, frame_index              | valid/ready
// rsp     | out | result_frame, status, was_used    | valid/ready
// cfg     | in  | cfg_index, cfg_data               | cfg_we, no back-pressure
//
// Free and query in the window go from acceptance through dispatch, lookup and done to rsp;
// refusals and an empty allocate window skip lookup. Allocate scans one 32-bit word per
// cycle from the reserved word until a free frame is found or the window ends.
// After reset a clearing pass zeroes the bitmap one word per cycle, ceil(MAX_FRAMES/32) words
// capped at 256, and takes no item until it ends. One item is in flight: the next is taken
// while a result waits in rsp, and its own result then holds until rsp frees.

module bitmap_frame_allocator_core #(
	parameter int unsigned MAX_FRAMES = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [bfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [bfa_pkg::CNT_W-1:0]        cfg_data,
	bfa_req_if.sink                          req,
	bfa_rsp_if.source                        rsp
);
	import bfa_pkg::*;

	logic [CNT_W-1:0] frame_total_q, reserved_q;
	dp_cmd_t          cmd;
	dp_status_t       st;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q <= FRAME_TOTAL_RST;
			reserved_q    <= RESERVED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_TOTAL: frame_total_q <= cfg_data;
				REG_RESERVED:    reserved_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: clearing pass, dispatch, lookup, scan, hand-off
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// bitmap memory, scan logic, result and output registers
	bfa_dpath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_total    (frame_total_q),
		.reserved_count (reserved_q),
		.command        (req.command),
		.frame_index    (req.frame_index),
		.out_ready      (rsp.ready),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (rsp.valid),
		.result_frame   (rsp.result_frame),
		.status         (rsp.status),
		.was_used       (rsp.was_used)
	);

	// hold a waiting result: load the output register only when it is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp.valid || rsp.ready))
		else $error("result loaded over a waiting item");

	// one item in flight: no acceptance in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second item accepted while busy");

	// an out-of-range result never reports a used frame
	a_range_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_RANGE) |-> !rsp.was_used)
		else $error("out-of-range result with used bit set");

	// never set and clear a bit in the same cycle
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_alloc && (cmd.wr_free || cmd.clr_en)))
		else $error("conflicting bitmap writes");

endmodule

`default_nettype wire

/* hdl/bfa_ctrl.sv */
`default_nettype none

module bfa_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  bfa_pkg::dp_status_t  st,
	output bfa_pkg::dp_cmd_t     cmd
);
	import bfa_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR    = 6'b000001,
		S_IDLE     = 6'b000010,
		S_DISPATCH = 6'b000100,
		S_LOOK     = 6'b001000,
		S_SCAN     = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.is_alloc) begin
					if (st.alloc_empty) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_FULL;
						state_d      = S_DONE;
					end else begin
						cmd.rd_init = 1'b1;
						state_d     = S_SCAN;
					end
				end else if (st.idx_range) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RANGE;
					state_d      = S_DONE;
				end else if (st.idx_resv) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_RESV;
					state_d      = S_DONE;
				end else begin
					cmd.rd_index = 1'b1;
					state_d      = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_LOOK;
				cmd.wr_free  = st.is_free;
				state_d      = S_DONE;
			end
			S_SCAN: begin
				if (st.found) begin
					cmd.wr_alloc = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ALLOC;
					state_d      = S_DONE;
				end else if (st.scan_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_FULL;
					state_d      = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/bfa_dpath.sv */
`default_nettype none

module bfa_dpath #(
	parameter int unsigned MAX_FRAMES = 4096
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [bfa_pkg::CNT_W-1:0]         frame_total,
	input  wire  [bfa_pkg::CNT_W-1:0]         reserved_count,
	input  wire  [bfa_pkg::CMD_W-1:0]         command,
	input  wire  [bfa_pkg::FRAME_W-1:0]       frame_index,
	input  wire                               out_ready,
	input  bfa_pkg::dp_cmd_t                  cmd,
	output bfa_pkg::dp_status_t               st,
	output logic                              out_valid,
	output logic [bfa_pkg::FRAME_W-1:0]       result_frame,
	output logic [bfa_pkg::STATUS_W-1:0]      status,
	output logic                              was_used
);
	import bfa_pkg::*;

	// frames at or above 8191 can never fall inside the window
	localparam int unsigned MAP_FRAMES = (MAX_FRAMES < 8192) ? MAX_FRAMES : 8192;
	localparam int unsigned NUM_WORDS  = (MAP_FRAMES + WORD_W - 1) / WORD_W;
	localparam int unsigned WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int unsigned CLAMP      = (MAX_FRAMES < 8191) ? MAX_FRAMES : 8191;

	logic [CNT_W-1:0]   total_eff, resv_eff;
	logic [CMD_W-1:0]   op_q;
	logic [FRAME_W-1:0] idx_q;
	logic [WORD_AW-1:0] clr_q, scan_q, raddr, waddr, idx_word, resv_word;
	logic [BIT_W-1:0]   idx_bit, pos;
	logic [WORD_W-1:0]  mem [NUM_WORDS];
	logic [WORD_W-1:0]  rdata_q, wdata, free_bits;
	logic [CNT_W:0]     base;
	logic               rd_en, we, found;

	logic [FRAME_W-1:0]  res_frame_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_used_q;
	logic                out_valid_q;

	assign total_eff = (frame_total > CNT_W'(CLAMP)) ? CNT_W'(CLAMP) : frame_total;
	assign resv_eff  = (reserved_count > total_eff) ? total_eff : reserved_count;

	assign idx_word  = WORD_AW'(idx_q >> BIT_W);
	assign idx_bit   = idx_q[BIT_W-1:0];
	assign resv_word = WORD_AW'(resv_eff >> BIT_W);
	assign base      = (CNT_W + 1)'(scan_q) << BIT_W;

	// mark frames outside the window as busy, then take the lowest free one
	always_comb begin
		logic [CNT_W:0] fr;
		free_bits = '0;
		for (int j = 0; j < int'(WORD_W); j++) begin
			fr = base + (CNT_W + 1)'(j);
			free_bits[j] = !rdata_q[j] && (fr >= {1'b0, resv_eff}) && (fr < {1'b0, total_eff});
		end
	end

	always_comb begin
		pos = '0;
		for (int j = int'(WORD_W) - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				pos = BIT_W'(j);
			end
		end
	end

	assign found = |free_bits;

	assign st.clr_last    = (clr_q == WORD_AW'(NUM_WORDS - 1));
	assign st.is_alloc    = (op_q == CMD_ALLOC);
	assign st.is_free     = (op_q == CMD_FREE);
	assign st.alloc_empty = (resv_eff >= total_eff);
	assign st.idx_range   = ({1'b0, idx_q} >= total_eff);
	assign st.idx_resv    = ({1'b0, idx_q} < resv_eff);
	assign st.found       = found;
	assign st.scan_last   = ((base + (CNT_W + 1)'(WORD_W)) >= {1'b0, total_eff});
	assign st.out_free    = !out_valid_q || out_ready;

	// read port
	assign rd_en = cmd.rd_init || cmd.rd_index || cmd.scan_step;
	always_comb begin
		if (cmd.rd_init) begin
			raddr = resv_word;
		end else if (cmd.rd_index) begin
			raddr = idx_word;
		end else begin
			raddr = scan_q + WORD_AW'(1);
		end
	end

	// write port
	assign we = cmd.clr_en || cmd.wr_alloc || cmd.wr_free;
	always_comb begin
		if (cmd.clr_en) begin
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.wr_alloc) begin
			waddr = scan_q;
			wdata = rdata_q | (WORD_W'(1) << pos);
		end else begin
			waddr = idx_word;
			wdata = rdata_q & ~(WORD_W'(1) << idx_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en && !st.clr_last) begin
			clr_q <= clr_q + WORD_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			op_q  <= command;
			idx_q <= frame_index;
		end
		if (cmd.rd_init) begin
			scan_q <= resv_word;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + WORD_AW'(1);
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_FULL: begin
					res_frame_q  <= '0;
					res_status_q <= ST_FULL;
					res_used_q   <= 1'b0;
				end
				RES_RANGE: begin
					res_frame_q  <= idx_q;
					res_status_q <= ST_RANGE;
					res_used_q   <= 1'b0;
				end
				RES_RESV: begin
					res_frame_q  <= idx_q;
					res_status_q <= (op_q == CMD_FREE) ? ST_RESERVED : ST_DONE;
					res_used_q   <= 1'b1;
				end
				RES_LOOK: begin
					res_frame_q  <= idx_q;
					res_status_q <= ST_DONE;
					res_used_q   <= rdata_q[idx_bit];
				end
				RES_ALLOC: begin
					res_frame_q  <= FRAME_W'(base + (CNT_W + 1)'(pos));
					res_status_q <= ST_DONE;
					res_used_q   <= 1'b0;
				end
				default: begin
					res_frame_q  <= idx_q;
					res_status_q <= ST_DONE;
					res_used_q   <= 1'b0;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_frame <= res_frame_q;
			status       <= res_status_q;
			was_used     <= res_used_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
